FILE: rtl/ihss_pkg.sv
// Shared types and constants for the image header size sniffer.
// Used by ihss_jpeg_walker and image_header_size_sniffer_top; no dependencies.
package ihss_pkg;

  // Number of leading file bytes kept for type and dimension checks (30).
  localparam int unsigned HeaderBytes = 30;
  // Counter wide enough to hold HeaderBytes itself, index wide enough to address it.
  localparam int unsigned CountW = $clog2(HeaderBytes + 1);
  localparam int unsigned IndexW = $clog2(HeaderBytes);

  // Marker and signature bytes
  localparam logic [7:0] ByteFf   = 8'hFF;
  localparam logic [7:0] ByteSoi  = 8'hD8;
  localparam logic [7:0] MarkSof0 = 8'hC0;
  localparam logic [7:0] MarkSof2 = 8'hC2;

  // File kind codes
  typedef enum logic [1:0] {
    KindUnknown = 2'd0,
    KindJpeg    = 2'd1,
    KindPng     = 2'd2,
    KindWebp    = 2'd3
  } kind_e;

  // Input beat: one file byte plus end-of-file flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  // Output beat: one result per file
  typedef struct packed {
    logic [1:0]  image_kind;
    logic [31:0] width;
    logic [31:0] height;
    logic        dims_valid;
  } out_beat_t;

  // Dimensions captured by the JPEG walker
  typedef struct packed {
    logic        found;
    logic [15:0] width;
    logic [15:0] height;
  } jpeg_dims_t;

endpackage

FILE: rtl/ihss_jpeg_walker.sv
// JPEG segment walker: follows marker segments and captures SOF0/SOF2 size.
// Depends on ihss_pkg.
module ihss_jpeg_walker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,   // walk this byte
  input  logic               clear_i,  // end of file, back to reset after this byte
  input  logic [7:0]         data_i,
  output ihss_pkg::jpeg_dims_t dims_o  // dimensions including this byte
);
  import ihss_pkg::*;

  typedef enum logic [2:0] {
    PhFf     = 3'd0,
    PhMarker = 3'd1,
    PhLenHi  = 3'd2,
    PhLenLo  = 3'd3,
    PhSkip   = 3'd4,
    PhSof    = 3'd5,
    PhStop   = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d, phase_w;
  logic [15:0] rem_q, rem_d, rem_w;
  logic [15:0] height_q, height_d, height_w;
  logic [15:0] width_q, width_d, width_w;
  logic        found_q, found_d, found_w;
  logic [15:0] seg_len;
  logic [15:0] rem_dec;

  assign seg_len = rem_q | {8'h00, data_i};
  assign rem_dec = rem_q - 16'd1;

  // One walker step on the current byte
  always_comb begin
    phase_w  = phase_q;
    rem_w    = rem_q;
    height_w = height_q;
    width_w  = width_q;
    found_w  = found_q;
    if (step_i) begin
      case (phase_q)
        PhFf: begin
          phase_w = (data_i == ByteFf) ? PhMarker : PhStop;
        end
        PhMarker: begin
          if (data_i == MarkSof0 || data_i == MarkSof2) begin
            rem_w   = 16'd0;
            phase_w = PhSof;
          end else begin
            phase_w = PhLenHi;
          end
        end
        PhLenHi: begin
          rem_w   = {data_i, 8'h00};
          phase_w = PhLenLo;
        end
        PhLenLo: begin
          if (seg_len[15:1] == 15'd0) begin
            phase_w = PhStop;
          end else if (seg_len == 16'd2) begin
            phase_w = PhFf;
          end else begin
            rem_w   = seg_len - 16'd2;
            phase_w = PhSkip;
          end
        end
        PhSkip: begin
          rem_w = rem_dec;
          if (rem_dec == 16'd0) begin
            phase_w = PhFf;
          end
        end
        PhSof: begin
          // offsets 3,4 height; 5,6 width (big endian)
          case (rem_q)
            16'd3: height_w = {data_i, 8'h00};
            16'd4: height_w = height_q | {8'h00, data_i};
            16'd5: width_w  = {data_i, 8'h00};
            16'd6: begin
              width_w = width_q | {8'h00, data_i};
              found_w = 1'b1;
              phase_w = PhStop;
            end
            default: ;
          endcase
          rem_w = rem_q + 16'd1;
        end
        default: ;  // stopped, or spare code
      endcase
    end
  end

  // End of file returns everything to reset
  always_comb begin
    if (clear_i) begin
      phase_d  = PhFf;
      rem_d    = 16'd0;
      height_d = 16'd0;
      width_d  = 16'd0;
      found_d  = 1'b0;
    end else begin
      phase_d  = phase_w;
      rem_d    = rem_w;
      height_d = height_w;
      width_d  = width_w;
      found_d  = found_w;
    end
  end

  assign dims_o.found  = found_w;
  assign dims_o.width  = width_w;
  assign dims_o.height = height_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhFf;
      rem_q    <= 16'd0;
      height_q <= 16'd0;
      width_q  <= 16'd0;
      found_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      rem_q    <= rem_d;
      height_q <= height_d;
      width_q  <= width_d;
      found_q  <= found_d;
    end
  end

  // Inside an SOF segment the index never passes the last width byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhSof) |-> (rem_q <= 16'd6))
    else $error("SOF index out of range");

endmodule

FILE: rtl/image_header_size_sniffer_top.sv
// Top level of the image header size sniffer: handshake, header store, result.
// Depends on ihss_pkg and ihss_jpeg_walker.

// Takes an image file one byte per beat, last_byte set on the final byte, and
// gives one result per file: the kind (JPEG, PNG, WebP or unknown) and, where
// found, width and height. A byte is taken every cycle; the result appears in
// the output register on the cycle after the final byte is accepted, and the
// next file may start right behind it. The input stalls only while a result
// sits in the output register and the receiver stalls it. The first
// HeaderBytes bytes are kept in flip-flops for the PNG and WebP checks; JPEG
// sizes come from a segment walker that follows the whole file.
module image_header_size_sniffer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ihss_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ihss_pkg::out_beat_t out_data_o
);
  import ihss_pkg::*;

  logic              in_accept;
  logic              walk_step;
  logic              file_end;
  logic [7:0]        hdr_q [HeaderBytes];
  logic [7:0]        hv [HeaderBytes];
  logic [CountW-1:0] count_q, count_d, n_bytes;
  jpeg_dims_t        jdims;
  out_beat_t         res;
  out_beat_t         out_q;
  logic              out_valid_q, out_valid_d;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign file_end   = in_accept && in_data_i.last_byte;
  assign walk_step  = in_accept && (count_q >= CountW'(2));

  ihss_jpeg_walker u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (walk_step),
    .clear_i (file_end),
    .data_i  (in_data_i.data_byte),
    .dims_o  (jdims)
  );

  // Header store fill
  always_ff @(posedge clk_i) begin
    if (in_accept && count_q < CountW'(HeaderBytes)) begin
      hdr_q[count_q[IndexW-1:0]] <= in_data_i.data_byte;
    end
  end

  // Bytes seen including this beat, saturating at the store size
  assign n_bytes = (count_q < CountW'(HeaderBytes)) ? count_q + CountW'(1) : count_q;

  always_comb begin
    count_d = count_q;
    if (file_end) begin
      count_d = '0;
    end else if (in_accept) begin
      count_d = n_bytes;
    end
  end

  // Store contents as seen with the current byte merged in
  always_comb begin
    for (int i = 0; i < HeaderBytes; i++) begin
      hv[i] = (count_q == CountW'(i)) ? in_data_i.data_byte : hdr_q[i];
    end
  end

  // File kind and dimensions
  always_comb begin
    logic is_jpeg, is_png, is_webp;
    logic tag_vp8, tag_vp8l, tag_vp8x;
    res = '0;
    res.image_kind = KindUnknown;
    is_jpeg = (n_bytes >= CountW'(2)) && hv[0] == ByteFf && hv[1] == ByteSoi;
    is_png  = (n_bytes >= CountW'(8)) &&
              hv[0] == 8'h89 && hv[1] == 8'h50 && hv[2] == 8'h4E && hv[3] == 8'h47 &&
              hv[4] == 8'h0D && hv[5] == 8'h0A && hv[6] == 8'h1A && hv[7] == 8'h0A;
    // "RIFF" .... "WEBP"
    is_webp = (n_bytes >= CountW'(12)) &&
              hv[0] == 8'h52 && hv[1] == 8'h49 && hv[2] == 8'h46 && hv[3] == 8'h46 &&
              hv[8] == 8'h57 && hv[9] == 8'h45 && hv[10] == 8'h42 && hv[11] == 8'h50;
    // "VP8" then ' ', 'L' or 'X'
    tag_vp8  = hv[12] == 8'h56 && hv[13] == 8'h50 && hv[14] == 8'h38 && hv[15] == 8'h20;
    tag_vp8l = hv[12] == 8'h56 && hv[13] == 8'h50 && hv[14] == 8'h38 && hv[15] == 8'h4C;
    tag_vp8x = hv[12] == 8'h56 && hv[13] == 8'h50 && hv[14] == 8'h38 && hv[15] == 8'h58;
    if (is_jpeg) begin
      res.image_kind = KindJpeg;
      if (jdims.found) begin
        res.width      = {16'h0000, jdims.width};
        res.height     = {16'h0000, jdims.height};
        res.dims_valid = 1'b1;
      end
    end else if (is_png) begin
      res.image_kind = KindPng;
      if (n_bytes >= CountW'(24)) begin
        res.width      = {hv[16], hv[17], hv[18], hv[19]};
        res.height     = {hv[20], hv[21], hv[22], hv[23]};
        res.dims_valid = 1'b1;
      end
    end else if (is_webp) begin
      res.image_kind = KindWebp;
      if (n_bytes >= CountW'(30)) begin
        if (tag_vp8) begin
          res.width      = {18'h0, hv[27][5:0], hv[26]};
          res.height     = {18'h0, hv[29][5:0], hv[28]};
          res.dims_valid = 1'b1;
        end else if (tag_vp8l) begin
          res.width      = 32'({hv[22][5:0], hv[21]}) + 32'd1;
          res.height     = 32'({hv[24][3:0], hv[23], hv[22][7:6]}) + 32'd1;
          res.dims_valid = 1'b1;
        end else if (tag_vp8x) begin
          res.width      = 32'({hv[26], hv[25], hv[24]}) + 32'd1;
          res.height     = 32'({hv[29], hv[28], hv[27]}) + 32'd1;
          res.dims_valid = 1'b1;
        end
      end
    end
  end

  // Result register: loads on the final byte, drains when not stalled
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (file_end) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (file_end) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A new result only follows an accepted final byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(file_end))
    else $error("result without final byte");

  // Fill count never passes the store size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(HeaderBytes))
    else $error("header count overflow");

  // Each file starts from an empty header store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    file_end |=> (count_q == '0 && out_valid_q))
    else $error("state not cleared after final byte");

endmodule

FILE: tb/tb_image_header_size_sniffer_top.sv
// Self-checking bench for image_header_size_sniffer_top: directed and random image files,
// predicted per byte against an in-bench model of the sniffer.
// Depends on ihss_pkg and the RTL of the top level only.
module tb_image_header_size_sniffer_top;
  import ihss_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // One byte waiting in the sender; drain_first holds it back until every result is in
  typedef struct {
    in_beat_t beat;
    bit       drain_first;
  } queued_beat_t;

  // JPEG segment walker phases
  typedef enum logic [2:0] {
    WkFf, WkMarker, WkLenHi, WkLenLo, WkSkip, WkSof, WkStop
  } walk_e;

  localparam logic [63:0] PngSig  = 64'h89504E470D0A1A0A;
  localparam logic [31:0] TagIhdr = "IHDR";
  localparam logic [31:0] TagRiff = "RIFF";
  localparam logic [31:0] TagWebp = "WEBP";
  localparam logic [31:0] TagVp8  = "VP8 ";
  localparam logic [31:0] TagVp8l = "VP8L";
  localparam logic [31:0] TagVp8x = "VP8X";
  localparam logic [7:0]  MarkApp0 = 8'hE0;
  localparam logic [7:0]  MarkDqt  = 8'hDB;
  localparam logic [7:0]  MarkEoi  = 8'hD9;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_data = '0;
  logic      out_valid_o;
  logic      out_stall = 1'b0;
  out_beat_t out_data_o;

  queued_beat_t file_bytes_q[$];
  out_beat_t    sniff_results_q[$];

  // Model of the sniffer state
  logic [7:0]  hdr_mem[HeaderBytes];
  int unsigned hdr_cnt = 0;
  walk_e       walk_ph = WkFf;
  logic [15:0] seg_left = '0;
  logic [15:0] sof_h = '0;
  logic [15:0] sof_w = '0;
  logic        sof_seen = 1'b0;

  int unsigned cyc = 0;
  int unsigned mismatches = 0;
  int unsigned files_queued = 0;
  int unsigned bytes_queued = 0;
  int unsigned results_seen = 0;
  int unsigned dims_seen = 0;
  int unsigned kind_seen[4] = '{0, 0, 0, 0};
  int unsigned hold_left = 0;
  bit          held = 1'b0;
  logic        quiet_win;

  assign quiet_win = (cyc >= 500) && (cyc < 900);

  image_header_size_sniffer_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  // Big-endian read of stored header bytes
  function automatic logic [63:0] hdr_be(int unsigned off, int unsigned count);
    logic [63:0] acc;
    acc = '0;
    for (int unsigned k = 0; k < count; k++) acc = {acc[55:0], hdr_mem[off + k]};
    return acc;
  endfunction

  // Advance the model by one accepted byte; queue the result on the final byte
  task automatic sniff_byte(input in_beat_t beat);
    logic [7:0]  b;
    logic [15:0] seg_len;
    logic [31:0] tag;
    out_beat_t   res;
    b = beat.data_byte;
    if (hdr_cnt >= 2) begin
      case (walk_ph)
        WkFf: walk_ph = (b == ByteFf) ? WkMarker : WkStop;
        WkMarker: begin
          if (b == MarkSof0 || b == MarkSof2) begin
            seg_left = '0;
            walk_ph = WkSof;
          end else begin
            walk_ph = WkLenHi;
          end
        end
        WkLenHi: begin
          seg_left = {b, 8'h00};
          walk_ph = WkLenLo;
        end
        WkLenLo: begin
          seg_len = seg_left | {8'h00, b};
          if (seg_len < 16'd2) begin
            walk_ph = WkStop;
          end else if (seg_len == 16'd2) begin
            walk_ph = WkFf;
          end else begin
            seg_left = seg_len - 16'd2;
            walk_ph = WkSkip;
          end
        end
        WkSkip: begin
          seg_left = seg_left - 16'd1;
          if (seg_left == '0) walk_ph = WkFf;
        end
        WkSof: begin
          // offsets 3,4 height, 5,6 width
          case (seg_left)
            16'd3: sof_h = {b, 8'h00};
            16'd4: sof_h[7:0] = b;
            16'd5: sof_w = {b, 8'h00};
            16'd6: begin
              sof_w[7:0] = b;
              sof_seen = 1'b1;
              walk_ph = WkStop;
            end
            default: ;
          endcase
          seg_left = seg_left + 16'd1;
        end
        default: ;
      endcase
    end
    if (hdr_cnt < HeaderBytes) begin
      hdr_mem[hdr_cnt] = b;
      hdr_cnt++;
    end
    if (beat.last_byte) begin
      res = '0;
      if (hdr_cnt >= 2 && hdr_be(0, 2) == 64'({ByteFf, ByteSoi})) begin
        res.image_kind = KindJpeg;
        if (sof_seen) begin
          res.width = {16'd0, sof_w};
          res.height = {16'd0, sof_h};
          res.dims_valid = 1'b1;
        end
      end else if (hdr_cnt >= 8 && hdr_be(0, 8) == PngSig) begin
        res.image_kind = KindPng;
        if (hdr_cnt >= 24) begin
          res.width = 32'(hdr_be(16, 4));
          res.height = 32'(hdr_be(20, 4));
          res.dims_valid = 1'b1;
        end
      end else if (hdr_cnt >= 12 && 32'(hdr_be(0, 4)) == TagRiff
                   && 32'(hdr_be(8, 4)) == TagWebp) begin
        res.image_kind = KindWebp;
        if (hdr_cnt >= 30) begin
          tag = 32'(hdr_be(12, 4));
          if (tag == TagVp8) begin
            res.width = {18'd0, hdr_mem[27][5:0], hdr_mem[26]};
            res.height = {18'd0, hdr_mem[29][5:0], hdr_mem[28]};
            res.dims_valid = 1'b1;
          end else if (tag == TagVp8l) begin
            res.width = 32'({hdr_mem[22][5:0], hdr_mem[21]}) + 32'd1;
            res.height = 32'({hdr_mem[24][3:0], hdr_mem[23], hdr_mem[22][7:6]}) + 32'd1;
            res.dims_valid = 1'b1;
          end else if (tag == TagVp8x) begin
            res.width = 32'({hdr_mem[26], hdr_mem[25], hdr_mem[24]}) + 32'd1;
            res.height = 32'({hdr_mem[29], hdr_mem[28], hdr_mem[27]}) + 32'd1;
            res.dims_valid = 1'b1;
          end
        end
      end
      sniff_results_q.push_back(res);
      // back to reset for the next file
      hdr_cnt = 0;
      walk_ph = WkFf;
      seg_left = '0;
      sof_h = '0;
      sof_w = '0;
      sof_seen = 1'b0;
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
    end
  endtask

  function automatic byte_q_t rand_bytes(int unsigned count);
    byte_q_t fb;
    fb = {};
    repeat (count) fb.push_back(8'($urandom));
    return fb;
  endfunction

  function automatic byte_q_t word_bytes(logic [31:0] w);
    byte_q_t fb;
    fb = {};
    for (int k = 3; k >= 0; k--) fb.push_back(w[8 * k +: 8]);
    return fb;
  endfunction

  // 24-byte PNG start: signature and IHDR with the given size
  function automatic byte_q_t png_head(logic [31:0] w, logic [31:0] h);
    byte_q_t fb;
    fb = {word_bytes(PngSig[63:32]), word_bytes(PngSig[31:0]), word_bytes(32'h0000000D)};
    fb = {fb, word_bytes(TagIhdr), word_bytes(w), word_bytes(h)};
    return fb;
  endfunction

  // 30-byte WebP start with the given chunk tag and random contents
  function automatic byte_q_t webp_head(logic [31:0] tag);
    byte_q_t fb;
    fb = {word_bytes(TagRiff), rand_bytes(4), word_bytes(TagWebp), word_bytes(tag)};
    fb = {fb, rand_bytes(14)};
    return fb;
  endfunction

  task automatic queue_file(input byte_q_t fb, input bit drain_first);
    queued_beat_t qb;
    foreach (fb[k]) begin
      qb.beat.data_byte = fb[k];
      qb.beat.last_byte = (k == fb.size() - 1);
      qb.drain_first = drain_first && (k == 0);
      file_bytes_q.push_back(qb);
    end
    files_queued++;
    bytes_queued += fb.size();
  endtask

  // Mostly well-formed files with random content, some noise, corruption and truncation
  task automatic random_file(output byte_q_t fb);
    int unsigned pick;
    int unsigned lim;
    logic [15:0] seg_len;
    logic [31:0] tag;
    pick = $urandom_range(99);
    if (pick < 12) begin
      fb = rand_bytes($urandom_range(12, 1));
    end else begin
      pick = $urandom_range(2);
      if (pick == 0) begin
        fb = '{ByteFf, ByteSoi};
        repeat ($urandom_range(3)) begin
          seg_len = ($urandom_range(15) == 0) ? 16'($urandom_range(64, 2))
                                              : 16'($urandom_range(7));
          fb.push_back(ByteFf);
          case ($urandom_range(4))
            0: fb.push_back(MarkApp0);
            1: fb.push_back(MarkDqt);
            2: fb.push_back(ByteFf);
            3: fb.push_back(MarkEoi);
            default: fb.push_back(8'($urandom));
          endcase
          fb.push_back(seg_len[15:8]);
          fb.push_back(seg_len[7:0]);
          if (seg_len > 16'd2) fb = {fb, rand_bytes(32'(seg_len) - 2)};
        end
        if ($urandom_range(9) < 7) begin
          fb.push_back(ByteFf);
          fb.push_back($urandom_range(1) ? MarkSof0 : MarkSof2);
          fb.push_back(8'h00);
          fb.push_back(8'h11);
          fb.push_back(8'h08);
          fb = {fb, rand_bytes(4 + $urandom_range(3))};
        end
      end else if (pick == 1) begin
        fb = {png_head($urandom, $urandom), rand_bytes($urandom_range(10))};
      end else begin
        case ($urandom_range(3))
          0: tag = TagVp8;
          1: tag = TagVp8l;
          2: tag = TagVp8x;
          default: tag = $urandom;
        endcase
        fb = {webp_head(tag), rand_bytes($urandom_range(6))};
      end
      // broken header byte
      if ($urandom_range(99) < 15) begin
        lim = (fb.size() > 16) ? 15 : fb.size() - 1;
        fb[$urandom_range(lim)] = 8'($urandom);
      end
      // file cut short
      if ($urandom_range(99) < 25) fb = fb[0 : $urandom_range(fb.size() - 1)];
    end
  endtask

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) cyc <= cyc + 1;

  // Sender: present the next byte, hold it while stalled
  always @(posedge clk_i) begin : feed_p
    queued_beat_t nxt;
    logic took;
    logic gap;
    logic hold_back;
    if (rst_ni) begin
      took = in_valid && !in_stall_o;
      if (took) sniff_byte(in_data);
      if (!in_valid || took) begin
        gap = !quiet_win && ($urandom_range(99) < 16);
        hold_back = file_bytes_q.size() != 0 && file_bytes_q[0].drain_first
                    && sniff_results_q.size() != 0;
        if (file_bytes_q.size() != 0 && !gap && !hold_back) begin
          nxt = file_bytes_q.pop_front();
          in_data <= nxt.beat;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result beat, stall at random and once for a long stretch
  always @(posedge clk_i) begin : watch_p
    out_beat_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        results_seen++;
        if (sniff_results_q.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing outstanding, got kind %0d", $time,
                   out_data_o.image_kind);
        end else begin
          want = sniff_results_q.pop_front();
          kind_seen[want.image_kind]++;
          if (want.dims_valid) dims_seen++;
          check_field("image_kind", 32'(want.image_kind), 32'(out_data_o.image_kind));
          check_field("width", want.width, out_data_o.width);
          check_field("height", want.height, out_data_o.height);
          check_field("dims_valid", 32'(want.dims_valid), 32'(out_data_o.dims_valid));
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (results_seen >= 8 && !held) begin
        held <= 1'b1;
        hold_left <= 300;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet_win && ($urandom_range(99) < 16);
      end
    end
  end

  // Stimulus and end of run
  initial begin : stim_p
    byte_q_t fb;
    int unsigned rnd_files;
    // single bytes and bare SOI
    queue_file('{8'h00}, 1'b0);
    queue_file('{ByteFf}, 1'b0);
    queue_file('{ByteFf, ByteSoi}, 1'b0);
    // APP0 then SOF0 with extreme sizes, trailing EOI
    queue_file('{ByteFf, ByteSoi, ByteFf, MarkApp0, 8'h00, 8'h04, 8'hAA, 8'hBB,
                 ByteFf, MarkSof0, 8'h00, 8'h11, 8'h08, 8'hFF, 8'hFF, 8'h00, 8'h01,
                 8'h03, ByteFf, MarkEoi}, 1'b0);
    // SOF2 right after SOI
    queue_file('{ByteFf, ByteSoi, ByteFf, MarkSof2, 8'h00, 8'h11, 8'h08, 8'h00, 8'h01,
                 8'hFF, 8'hFF, 8'h03}, 1'b0);
    // SOF cut inside the width bytes
    queue_file('{ByteFf, ByteSoi, ByteFf, MarkSof0, 8'h00, 8'h11, 8'h08, 8'h12, 8'h34,
                 8'h56}, 1'b0);
    // walker stops: non-FF segment start, length one, length zero
    queue_file('{ByteFf, ByteSoi, 8'h00, ByteFf, MarkSof0, 8'h00, 8'h11, 8'h08, 8'h00,
                 8'h10, 8'h00, 8'h10}, 1'b0);
    queue_file('{ByteFf, ByteSoi, ByteFf, 8'hE1, 8'h00, 8'h01, ByteFf, MarkSof0, 8'h00,
                 8'h11, 8'h08, 8'h00, 8'h10, 8'h00, 8'h10}, 1'b0);
    queue_file('{ByteFf, ByteSoi, ByteFf, 8'hE1, 8'h00, 8'h00, ByteFf, MarkSof0, 8'h00,
                 8'h11, 8'h08, 8'h00, 8'h10, 8'h00, 8'h10}, 1'b0);
    // empty segment of length two, then SOF0
    queue_file('{ByteFf, ByteSoi, ByteFf, 8'hE2, 8'h00, 8'h02, ByteFf, MarkSof0, 8'h00,
                 8'h11, 8'h08, 8'h00, 8'h20, 8'h00, 8'h40}, 1'b0);
    // FF and EOI markers walked as ordinary segments
    queue_file('{ByteFf, ByteSoi, ByteFf, ByteFf, 8'h00, 8'h03, 8'hAA, ByteFf, MarkEoi,
                 8'h00, 8'h02, ByteFf, MarkSof2, 8'h00, 8'h11, 8'h08, 8'h02, 8'h00,
                 8'h03, 8'h00}, 1'b0);
    // SOF lying past the stored header
    fb = '{ByteFf, ByteSoi, ByteFf, MarkApp0, 8'h00, 8'h1C};
    fb = {fb, rand_bytes(26)};
    fb = {fb, '{ByteFf, MarkSof0, 8'h00, 8'h11, 8'h08, 8'h0A, 8'hBC, 8'h0D, 8'hEF, 8'h01}};
    queue_file(fb, 1'b0);
    // PNG: full size extremes after a drain, one byte short, bare and partial signature
    queue_file(png_head(32'hFFFFFFFF, 32'h00000000), 1'b1);
    fb = png_head(32'h00000001, 32'h00000002);
    queue_file(fb[0:22], 1'b0);
    queue_file(fb[0:7], 1'b0);
    queue_file(fb[0:6], 1'b0);
    // WebP chunk kinds with all-ones size fields
    fb = webp_head(TagVp8);
    for (int k = 26; k < 30; k++) fb[k] = 8'hFF;
    queue_file(fb, 1'b0);
    fb = webp_head(TagVp8l);
    for (int k = 21; k < 25; k++) fb[k] = 8'hFF;
    queue_file(fb, 1'b0);
    fb = webp_head(TagVp8x);
    for (int k = 24; k < 30; k++) fb[k] = 8'hFF;
    queue_file(fb, 1'b0);
    // WebP too short for sizes, minimal WebP, one byte short of it
    fb = webp_head(TagVp8x);
    queue_file(fb[0:28], 1'b0);
    queue_file(fb[0:11], 1'b0);
    queue_file(fb[0:10], 1'b0);

    rnd_files = 0;
    while (bytes_queued < 420 || rnd_files < 2) begin
      random_file(fb);
      queue_file(fb, rnd_files == 0);
      rnd_files++;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (file_bytes_q.size() != 0 || in_valid || sniff_results_q.size() != 0)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    $display("%0d files, %0d bytes, %0d results checked (%0d with sizes)",
             files_queued, bytes_queued, results_seen, dims_seen);
    $display("kinds unknown/jpeg/png/webp %0d/%0d/%0d/%0d, long output hold-off and drains done",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(8 * 200000);
    $display("timeout after %0d cycles", cyc);
    $display("status: fail");
    $finish;
  end

endmodule
